// ===== design/lcgf_pkg.sv =====
// Shared types and constants for the LCG / lagged Fibonacci generator.
`default_nettype none
package lcgf_pkg;
  localparam int MAX_LAG_DEF   = 64;
  localparam int FRAC_BITS_DEF = 32;
  localparam int LAG_W         = 7;
  localparam int MOD_W         = 33;

  typedef enum logic [2:0] {
    REG_GEN_SEL = 3'd0,
    REG_LCG_MUL = 3'd1,
    REG_LCG_INC = 3'd2,
    REG_LCG_MOD = 3'd3,
    REG_LCG_START = 3'd4,
    REG_LAG_A = 3'd5,
    REG_LAG_B = 3'd6
  } reg_idx_t;

  // draw request to the congruential unit and its answer
  typedef struct packed {
    logic start;
  } lcg_req_t;

  typedef struct packed {
    logic done;
  } lcg_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED_REQ,
    ST_SEED_WAIT,
    ST_LCG_WAIT,
    ST_LFG_RD,
    ST_LFG_WAIT,
    ST_LFG_ADD,
    ST_MUL,
    ST_OUT
  } ctl_state_t;
endpackage
`default_nettype wire

// ===== design/lcgf_lcg.sv =====
// Congruential engine: multiply, iterative modulo, iterative fraction division.
`default_nettype none
module lcgf_lcg #(
  parameter int FRAC_BITS = lcgf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [31:0]           mul_i,
  input  wire logic [31:0]           inc_i,
  input  wire logic [32:0]           mod_i,
  input  wire logic                  load_i,
  input  wire logic [31:0]           load_val_i,
  input  wire lcgf_pkg::lcg_req_t    req_i,
  output lcgf_pkg::lcg_rsp_t         rsp_o,
  output logic [FRAC_BITS-1:0]       frac_o
);
  import lcgf_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 66);

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_MOD, L_DIV, L_DONE} lst_t;

  lst_t              st_r, st_nxt;
  logic [31:0]       s_r;
  logic [64:0]       t_r;      // product plus increment, shifted out from the top during modulo
  logic [64:0]       rem_r;    // restoring remainder
  logic [CNT_W-1:0]  cnt_r;
  logic [FRAC_BITS-1:0] q_r;
  logic [32:0]       m_eff;
  logic [33:0]       d;
  logic [65:0]       rem_sh;
  logic [65:0]       div_sh;

  assign m_eff = (mod_i == 33'd0 || mod_i > {1'b1, 32'd0}) ? {1'b1, 32'd0} : mod_i;
  assign d     = {1'b0, m_eff} + 34'd1;

  // binary long division: reduce mod m bit by bit from the top of t
  assign rem_sh = {rem_r, t_r[64]};
  assign div_sh = {rem_r, 1'b0};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      L_IDLE:  if (req_i.start) st_nxt = L_MUL;
      L_MUL:   st_nxt = L_MOD;
      L_MOD:   if (cnt_r == CNT_W'(64)) st_nxt = L_DIV;
      L_DIV:   if (cnt_r == CNT_W'(FRAC_BITS - 1)) st_nxt = L_DONE;
      L_DONE:  st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= L_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= 32'd1;
    end else if (load_i) begin
      s_r <= load_val_i;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          cnt_r <= '0;
        end
        L_MUL: begin
          t_r   <= 65'(64'(mul_i) * 64'(s_r)) + 65'(inc_i);
          rem_r <= '0;
          cnt_r <= '0;
        end
        L_MOD: begin
          if (rem_sh >= 66'(m_eff)) rem_r <= 65'(rem_sh - 66'(m_eff));
          else                      rem_r <= rem_sh[64:0];
          t_r   <= {t_r[63:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(64)) begin
            cnt_r <= '0;
            q_r   <= '0;
          end
        end
        L_DIV: begin
          // s < d, so integer quotient is zero
          if (cnt_r == CNT_W'(0)) begin
            s_r <= rem_r[31:0];
            if ({rem_r[64:0], 1'b0} >= 66'(d)) begin
              rem_r <= 65'({rem_r, 1'b0} - 66'(d));
              q_r   <= {q_r[FRAC_BITS-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[63:0], 1'b0};
              q_r   <= {q_r[FRAC_BITS-2:0], 1'b0};
            end
          end else if (div_sh >= 66'(d)) begin
            rem_r <= 65'(div_sh - 66'(d));
            q_r   <= {q_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_r <= div_sh[64:0];
            q_r   <= {q_r[FRAC_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CNT_W'(1);
        end
        L_DONE: ;
        default: ;
      endcase
    end
  end

  assign rsp_o.done = (st_r == L_DONE);
  assign frac_o     = q_r;
endmodule
`default_nettype wire

// ===== design/lcg_lagged_fibonacci_rng_unit.sv =====
// Top level: uniform random generator with congruential and lagged Fibonacci engines.
//
// Input channel (in_valid/in_ready) carries mode, range_low, range_high.
// mode 0 draws one number and emits one transfer on out_*; mode 1 reseeds the
// lag ring from MAX_LAG-limited p congruential draws and emits nothing.
// One item is in flight at a time; in_ready is high only when idle.
// Congruential draw: a multiply, then the bit-serial 65-step modulo
// and the FRAC_BITS-step fraction division in lcgf_lcg.
// Lagged draw: a ring memory read of two entries and a write-back of their sum;
// a lag change that leaves the head at or past the new p makes ST_LFG_RD take p off until it is below p.
// Scaling adds a multiply state (ST_MUL). Reseed runs p congruential draws.
// After reset the ring memory is cleared one entry per cycle
// before the first item is taken; configuration writes are taken throughout.
// The result waits in an output register while out_ready is low; the next
// item is accepted only once it has been transferred.
`default_nettype none
module lcg_lagged_fibonacci_rng_unit #(
  parameter int MAX_LAG   = lcgf_pkg::MAX_LAG_DEF,
  parameter int FRAC_BITS = lcgf_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic                    out_engine_used,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [32:0]        cfg_data
);
  import lcgf_pkg::*;

  localparam int AW  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int PW  = $clog2(MAX_LAG + 1);

  logic        gen_sel_r;
  logic [31:0] mul_r, inc_r;
  logic [32:0] mod_r;
  logic [LAG_W-1:0] lag_a_r, lag_b_r;
  logic        load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_sel_r <= 1'b0;
      mul_r     <= 32'd1;
      inc_r     <= 32'd0;
      mod_r     <= {1'b1, 32'd0};
      lag_a_r   <= LAG_W'(2);
      lag_b_r   <= LAG_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GEN_SEL:   gen_sel_r <= cfg_data[0];
        REG_LCG_MUL:   mul_r     <= cfg_data[31:0];
        REG_LCG_INC:   inc_r     <= cfg_data[31:0];
        REG_LCG_MOD:   mod_r     <= cfg_data;
        REG_LAG_A:     lag_a_r   <= cfg_data[LAG_W-1:0];
        REG_LAG_B:     lag_b_r   <= cfg_data[LAG_W-1:0];
        default: ;
      endcase
    end
  end
  assign load = cfg_we && (cfg_index == REG_LCG_START);

  // effective lags
  logic [PW-1:0] pa, pb, p, q;
  function automatic logic [PW-1:0] clamp_lag(input logic [LAG_W-1:0] v);
    if (v == '0) return PW'(1);
    if (32'(v) > 32'(MAX_LAG)) return PW'(MAX_LAG);
    return PW'(v);
  endfunction
  assign pa = clamp_lag(lag_a_r);
  assign pb = clamp_lag(lag_b_r);
  assign p  = (pa > pb) ? pa : pb;
  assign q  = (pa > pb) ? pb : pa;

  // congruential engine
  lcg_req_t lreq;
  lcg_rsp_t lrsp;
  logic [FRAC_BITS-1:0] lfrac;
  lcgf_lcg #(.FRAC_BITS(FRAC_BITS)) u_lcg (
    .clk(clk), .rst_n(rst_n), .mul_i(mul_r), .inc_i(inc_r), .mod_i(mod_r),
    .load_i(load), .load_val_i(cfg_data[31:0]), .req_i(lreq), .rsp_o(lrsp),
    .frac_o(lfrac)
  );

  // ring memory
  logic [FRAC_BITS-1:0] ring [MAX_LAG];
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [FRAC_BITS-1:0] wdata, rdata_r;
  always_ff @(posedge clk) begin
    if (we) ring[waddr] <= wdata;
    rdata_r <= ring[raddr];
  end

  ctl_state_t st_r, st_nxt;
  logic [PW-1:0]  head_r, cnt_r;
  logic [FRAC_BITS-1:0] x0_r, frac_r;
  logic signed [31:0]   low_r, high_r;
  logic signed [32:0]   span;
  logic signed [FRAC_BITS+33:0] prod;
  logic signed [31:0]   val_r;
  logic [PW-1:0]  h, k;
  logic [PW:0]    ksum;

  // ST_LFG_RD takes p off the head until it is below p
  assign h    = (head_r >= p) ? head_r - p : head_r;
  assign ksum = {1'b0, h} + {1'b0, p - q};
  assign k    = (ksum >= {1'b0, p}) ? PW'(ksum - {1'b0, p}) : ksum[PW-1:0];

  assign span = 33'(high_r) - 33'(low_r);
  assign prod = span * $signed({1'b0, frac_r});

  always_comb begin
    st_nxt     = st_r;
    lreq.start = 1'b0;
    we         = 1'b0;
    waddr      = AW'(h);
    wdata      = '0;
    raddr      = AW'(h);
    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = AW'(cnt_r); wdata = '0;
        if (cnt_r == PW'(MAX_LAG - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_valid) begin
        if (in_mode) st_nxt = ST_SEED_REQ;
        else if (gen_sel_r) st_nxt = ST_LFG_RD;
        else begin st_nxt = ST_LCG_WAIT; lreq.start = 1'b1; end
      end
      ST_SEED_REQ: begin lreq.start = 1'b1; st_nxt = ST_SEED_WAIT; end
      ST_SEED_WAIT: if (lrsp.done) begin
        we = 1'b1; waddr = AW'(cnt_r); wdata = lfrac;
        st_nxt = (cnt_r == p - PW'(1)) ? ST_IDLE : ST_SEED_REQ;
      end
      ST_LCG_WAIT: if (lrsp.done) st_nxt = ST_MUL;
      ST_LFG_RD: begin
        raddr = AW'(h);
        if (head_r < p) st_nxt = ST_LFG_WAIT;
      end
      ST_LFG_WAIT: begin raddr = AW'(k); st_nxt = ST_LFG_ADD; end
      ST_LFG_ADD: begin
        we = 1'b1; waddr = AW'(h); wdata = x0_r + rdata_r;
        st_nxt = ST_MUL;
      end
      ST_MUL: st_nxt = ST_OUT;
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_CLEAR: cnt_r <= cnt_r + PW'(1);
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin low_r <= in_range_low; high_r <= in_range_high; end
        end
        ST_SEED_WAIT: if (lrsp.done) begin
          cnt_r <= cnt_r + PW'(1);
          head_r <= '0;
        end
        ST_LCG_WAIT: if (lrsp.done) frac_r <= lfrac;
        ST_LFG_RD: if (head_r >= p) head_r <= h;
        ST_LFG_WAIT: x0_r <= rdata_r;
        ST_LFG_ADD: begin
          frac_r <= x0_r + rdata_r;
          head_r <= (h + PW'(1) == p) ? '0 : h + PW'(1);
        end
        ST_MUL: val_r <= low_r + 32'(prod >>> FRAC_BITS);
        default: ;
      endcase
    end
  end

  assign in_ready        = (st_r == ST_IDLE);
  assign out_valid       = (st_r == ST_OUT);
  assign out_value       = val_r;
  assign out_engine_used = gen_sel_r;
endmodule
`default_nettype wire

// ===== design/lcgf_checker.sv =====
// Port-level checker for the generator, bound to the top level.
`default_nettype none
module lcgf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("out hold");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind lcg_lagged_fibonacci_rng_unit lcgf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value)
);
`default_nettype wire
